[rtl/rtdal_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtdal_pkg
// Shared constants, command codes and controller/datapath handshake types
// for the RTD average-and-linearize block.
// ---------------------------------------------------------------------------
package rtdal_pkg;

  localparam int AVG_DEPTH = 16;
  localparam int RING_IDX_W = $clog2(AVG_DEPTH);
  localparam int AVG_CNT_W = 5;
  localparam logic [AVG_CNT_W-1:0] AVG_DEPTH_C = AVG_CNT_W'(AVG_DEPTH);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 41;

  localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_OHMS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOM_OHMS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd4;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_STUCK = 2'd2;

  localparam logic signed [18:0] T_MAX = 19'sd262143;

  // datapath operations
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_RING_WR = 4'd2;
  localparam logic [3:0] OP_SUM_STEP = 4'd3;
  localparam logic [3:0] OP_MEAN_INIT = 4'd4;
  localparam logic [3:0] OP_MEAN_DONE = 4'd5;
  localparam logic [3:0] OP_XMUL_INIT = 4'd6;
  localparam logic [3:0] OP_MUL_STEP = 4'd7;
  localparam logic [3:0] OP_XDIV_INIT = 4'd8;
  localparam logic [3:0] OP_DIV_STEP = 4'd9;
  localparam logic [3:0] OP_UMUL_INIT = 4'd10;
  localparam logic [3:0] OP_ASQ_INIT = 4'd11;
  localparam logic [3:0] OP_DISC = 4'd12;
  localparam logic [3:0] OP_SQRT_STEP = 4'd13;
  localparam logic [3:0] OP_QDIV_INIT = 4'd14;
  localparam logic [3:0] OP_FINISH = 4'd15;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic fault;
    logic zero;
    logic avg_on;
    logic step_last;
    logic sum_last;
    logic disc_neg;
  } dp_stat_t;

endpackage

[rtl/rtdal_channels.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtdal channels
// Valid/ready channels for raw readings and for results.
// ---------------------------------------------------------------------------
interface rtdal_in_if;
  logic valid;
  logic ready;
  logic [7:0] code_high_byte;
  logic [7:0] code_low_byte;

  modport source (output valid, output code_high_byte, output code_low_byte, input ready);
  modport sink (input valid, input code_high_byte, input code_low_byte, output ready);
endinterface

interface rtdal_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [14:0] code_out;
  logic signed [18:0] temperature_q8;

  modport source (output valid, output status, output code_out, output temperature_q8,
                  input ready);
  modport sink (input valid, input status, input code_out, input temperature_q8,
                output ready);
endinterface

[rtl/rtdal_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtdal_ctrl
// Sequencer: steps the datapath through averaging, ratio divide,
// discriminant, square root and final divide; owns the handshakes.
// ---------------------------------------------------------------------------
module rtdal_ctrl
  import rtdal_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHECK = 5'd1;
  localparam logic [4:0] S_SUM = 5'd2;
  localparam logic [4:0] S_MINIT = 5'd3;
  localparam logic [4:0] S_MDIV = 5'd4;
  localparam logic [4:0] S_MDONE = 5'd5;
  localparam logic [4:0] S_XMINIT = 5'd6;
  localparam logic [4:0] S_XMUL = 5'd7;
  localparam logic [4:0] S_XDINIT = 5'd8;
  localparam logic [4:0] S_XDIV = 5'd9;
  localparam logic [4:0] S_UINIT = 5'd10;
  localparam logic [4:0] S_UMUL = 5'd11;
  localparam logic [4:0] S_AINIT = 5'd12;
  localparam logic [4:0] S_AMUL = 5'd13;
  localparam logic [4:0] S_DISC = 5'd14;
  localparam logic [4:0] S_SQRT = 5'd15;
  localparam logic [4:0] S_QINIT = 5'd16;
  localparam logic [4:0] S_QDIV = 5'd17;
  localparam logic [4:0] S_FINISH = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.fault || stat.zero) begin
          state_next = S_FINISH;
        end else if (stat.avg_on) begin
          cmd.op = OP_RING_WR;
          state_next = S_SUM;
        end else begin
          cmd.op = OP_XMUL_INIT;
          state_next = S_XMUL;
        end
      end
      S_SUM: begin
        cmd.op = OP_SUM_STEP;
        if (stat.sum_last) state_next = S_MINIT;
      end
      S_MINIT: begin
        cmd.op = OP_MEAN_INIT;
        state_next = S_MDIV;
      end
      S_MDIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.step_last) state_next = S_MDONE;
      end
      S_MDONE: begin
        cmd.op = OP_MEAN_DONE;
        state_next = S_XMINIT;
      end
      S_XMINIT: begin
        cmd.op = OP_XMUL_INIT;
        state_next = S_XMUL;
      end
      S_XMUL: begin
        cmd.op = OP_MUL_STEP;
        if (stat.step_last) state_next = S_XDINIT;
      end
      S_XDINIT: begin
        cmd.op = OP_XDIV_INIT;
        state_next = S_XDIV;
      end
      S_XDIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.step_last) state_next = S_UINIT;
      end
      S_UINIT: begin
        cmd.op = OP_UMUL_INIT;
        state_next = S_UMUL;
      end
      S_UMUL: begin
        cmd.op = OP_MUL_STEP;
        if (stat.step_last) state_next = S_AINIT;
      end
      S_AINIT: begin
        cmd.op = OP_ASQ_INIT;
        state_next = S_AMUL;
      end
      S_AMUL: begin
        cmd.op = OP_MUL_STEP;
        if (stat.step_last) state_next = S_DISC;
      end
      S_DISC: begin
        cmd.op = OP_DISC;
        state_next = stat.disc_neg ? S_FINISH : S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (stat.step_last) state_next = S_QINIT;
      end
      S_QINIT: begin
        cmd.op = OP_QDIV_INIT;
        state_next = S_QDIV;
      end
      S_QDIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.step_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        // wait until the result register is free
        if (out_free) begin
          cmd.op = OP_FINISH;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/rtdal_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtdal_datapath
// Config registers, sample ring, serial multiplier, restoring divider,
// bit-pair square root and the result register.
// ---------------------------------------------------------------------------
module rtdal_datapath
  import rtdal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic [7:0]            code_high_byte,
  input  logic [7:0]            code_low_byte,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [1:0]            status,
  output logic [14:0]           code_out,
  output logic signed [18:0]    temperature_q8
);

  // configuration
  logic [AVG_CNT_W-1:0] avg_count;
  logic [23:0]          ref_ohms;
  logic [23:0]          nom_ohms;
  logic [30:0]          coef_a;
  logic [40:0]          coef_b;

  // ring
  logic [14:0]          ring [AVG_DEPTH];
  logic [AVG_CNT_W-1:0] ring_pos;
  logic [RING_IDX_W-1:0] sum_idx;
  logic [18:0]          sum;

  // item
  logic [14:0] code_cur;
  logic        fault_r;
  logic        zero_r;
  logic        ovf_r;
  logic        u_neg;
  logic        t_neg;
  logic [61:0] t_reg;

  // shared iterative units
  logic [6:0]  step_cnt;
  logic [63:0] m_acc;
  logic [63:0] m_cand;
  logic [30:0] m_plier;
  logic [63:0] d_num;
  logic [40:0] d_rem;
  logic [40:0] d_den;
  logic [63:0] s_rem;
  logic [63:0] s_res;
  logic [63:0] s_bit;

  logic [AVG_CNT_W-1:0] cnt_eff;
  logic [AVG_CNT_W-1:0] pos_eff;
  logic [23:0]          r0_eff;
  logic [41:0]          b_diff;
  logic [40:0]          bmag;
  logic [24:0]          x_sat;
  logic [23:0]          u_mag;
  logic [41:0]          rem_sh;
  logic                 q_bit;
  logic [63:0]          s_trial;
  logic [63:0]          disc;
  logic [31:0]          s_val;
  logic                 s_gt_a;
  logic [31:0]          mag;
  logic [55:0]          qdvd;
  logic [16:0]          qn;
  logic [17:0]          qp;
  logic [14:0]          code_in;

  assign code_in = {code_high_byte, code_low_byte[7:1]};

  always_comb begin
    if (avg_count == '0) cnt_eff = AVG_CNT_W'(1);
    else if (avg_count > AVG_DEPTH_C) cnt_eff = AVG_DEPTH_C;
    else cnt_eff = avg_count;
  end

  assign pos_eff = (ring_pos >= cnt_eff) ? '0 : ring_pos;
  assign r0_eff = (nom_ohms == '0) ? 24'd1 : nom_ohms;
  assign b_diff = {1'b1, 41'd0} - {1'b0, coef_b};
  assign bmag = coef_b[40] ? b_diff[40:0] : 41'd1;

  // ratio saturates at 16.0 in q20
  assign x_sat = (d_num > 64'd16777216) ? 25'd16777216 : d_num[24:0];
  assign u_mag = (x_sat <= 25'd1048576) ? 24'(25'd1048576 - x_sat)
                                        : 24'(x_sat - 25'd1048576);

  assign rem_sh = {d_rem, d_num[63]};
  assign q_bit = (rem_sh >= {1'b0, d_den});
  assign s_trial = s_res + s_bit;

  assign disc = u_neg ? ({2'b0, m_acc[61:0]} - {2'b0, t_reg})
                      : ({2'b0, m_acc[61:0]} + {2'b0, t_reg});

  assign s_val = s_res[31:0];
  assign s_gt_a = (s_val > {1'b0, coef_a});
  assign mag = s_gt_a ? (s_val - {1'b0, coef_a}) : ({1'b0, coef_a} - s_val);
  assign qdvd = {1'b0, mag, 23'd0} + {16'd0, bmag[40:1]};

  assign qn = (d_num > 64'd65536) ? 17'd65536 : d_num[16:0];
  assign qp = (d_num > 64'd262143) ? 18'd262143 : d_num[17:0];

  assign stat.fault = fault_r;
  assign stat.zero = zero_r;
  assign stat.avg_on = (cnt_eff > AVG_CNT_W'(1));
  assign stat.step_last = (step_cnt == 7'd1);
  assign stat.sum_last = ({1'b0, sum_idx} == (cnt_eff - AVG_CNT_W'(1)));
  assign stat.disc_neg = u_neg && (t_reg > m_acc[61:0]);

  // configuration and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count <= AVG_CNT_W'(1);
      ref_ohms <= 24'd110080;
      nom_ohms <= 24'd25600;
      coef_a <= 31'd16786021;
      coef_b <= 41'h1FFF64FA809;
      ring_pos <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) ring[i] <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_AVG_COUNT: avg_count <= wr_data[AVG_CNT_W-1:0];
          REG_REF_OHMS:  ref_ohms <= wr_data[23:0];
          REG_NOM_OHMS:  nom_ohms <= wr_data[23:0];
          REG_COEF_A:    coef_a <= wr_data[30:0];
          REG_COEF_B:    coef_b <= wr_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_RING_WR) begin
        ring[pos_eff[RING_IDX_W-1:0]] <= code_cur;
        ring_pos <= pos_eff + AVG_CNT_W'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        code_cur <= code_in;
        fault_r <= code_low_byte[0];
        zero_r <= (code_in == '0);
        ovf_r <= 1'b0;
      end
      OP_RING_WR: begin
        sum <= '0;
        sum_idx <= '0;
      end
      OP_SUM_STEP: begin
        sum <= sum + {4'd0, ring[sum_idx]};
        sum_idx <= sum_idx + RING_IDX_W'(1);
      end
      OP_MEAN_INIT: begin
        d_num <= {sum, 45'd0};
        d_rem <= '0;
        d_den <= {36'd0, cnt_eff};
        step_cnt <= 7'd19;
      end
      OP_MEAN_DONE: begin
        code_cur <= d_num[14:0];
      end
      OP_XMUL_INIT: begin
        m_acc <= '0;
        m_cand <= {49'd0, code_cur};
        m_plier <= {7'd0, ref_ohms};
        step_cnt <= 7'd24;
      end
      OP_MUL_STEP: begin
        if (m_plier[0]) m_acc <= m_acc + m_cand;
        m_cand <= {m_cand[62:0], 1'b0};
        m_plier <= {1'b0, m_plier[30:1]};
        step_cnt <= step_cnt - 7'd1;
      end
      OP_XDIV_INIT: begin
        // code * rref * 32, left aligned for 44 quotient bits
        d_num <= {m_acc[38:0], 5'd0, 20'd0};
        d_rem <= '0;
        d_den <= {17'd0, r0_eff};
        step_cnt <= 7'd44;
      end
      OP_DIV_STEP: begin
        d_rem <= q_bit ? 41'(rem_sh - {1'b0, d_den}) : rem_sh[40:0];
        d_num <= {d_num[62:0], q_bit};
        step_cnt <= step_cnt - 7'd1;
      end
      OP_UMUL_INIT: begin
        u_neg <= (x_sat > 25'd1048576);
        m_acc <= '0;
        m_cand <= {23'd0, bmag};
        m_plier <= {7'd0, u_mag};
        step_cnt <= 7'd24;
      end
      OP_ASQ_INIT: begin
        t_reg <= m_acc[63:2];
        m_acc <= '0;
        m_cand <= {33'd0, coef_a};
        m_plier <= coef_a;
        step_cnt <= 7'd31;
      end
      OP_DISC: begin
        ovf_r <= stat.disc_neg;
        s_rem <= disc;
        s_res <= '0;
        s_bit <= 64'h4000_0000_0000_0000;
        step_cnt <= 7'd32;
      end
      OP_SQRT_STEP: begin
        if (s_rem >= s_trial) begin
          s_rem <= s_rem - s_trial;
          s_res <= {1'b0, s_res[63:1]} + s_bit;
        end else begin
          s_res <= {1'b0, s_res[63:1]};
        end
        s_bit <= {2'b0, s_bit[63:2]};
        step_cnt <= step_cnt - 7'd1;
      end
      OP_QDIV_INIT: begin
        t_neg <= s_gt_a;
        d_num <= {qdvd, 8'd0};
        d_rem <= '0;
        d_den <= bmag;
        step_cnt <= 7'd56;
      end
      OP_FINISH: begin
        if (fault_r) begin
          status <= ST_FAULT;
          code_out <= code_cur;
          temperature_q8 <= '0;
        end else if (zero_r) begin
          status <= ST_STUCK;
          code_out <= '0;
          temperature_q8 <= '0;
        end else begin
          status <= ST_VALID;
          code_out <= code_cur;
          if (ovf_r) temperature_q8 <= T_MAX;
          else if (t_neg) temperature_q8 <= 19'(20'd0 - {3'd0, qn});
          else temperature_q8 <= {1'b0, qp};
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/rtd_average_and_linearize.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_average_and_linearize
// RTD reading to averaged code and temperature in 1/256 degC.
// flow: fault and stuck readings skip the arithmetic; others go through
//   averaging when enabled, the shared serial multiplier, the one-bit-per-cycle
//   divider (up to three divides) and the 32-step square root; a negative
//   discriminant skips the square root and the final divide
// throughput: a new reading is taken only after the last one has reached
//   the output register, where a finished beat waits while the next is taken
// reset: synchronous; config registers to defaults, sample ring cleared at once
// ---------------------------------------------------------------------------
module rtd_average_and_linearize
  import rtdal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  rtdal_in_if.sink              sample_in,
  rtdal_out_if.source           result_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rtdal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rtdal_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .code_high_byte (sample_in.code_high_byte),
    .code_low_byte  (sample_in.code_low_byte),
    .cmd            (cmd),
    .stat           (stat),
    .status         (result_out.status),
    .code_out       (result_out.code_out),
    .temperature_q8 (result_out.temperature_q8)
  );

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (sample_in.valid && sample_in.ready) |-> cmd.op == OP_LOAD)
    else $error("accepted beat not loaded");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FINISH |=> result_out.valid)
    else $error("finished result not presented");

  a_temp_zero: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.status != ST_VALID) |-> result_out.temperature_q8 == '0)
    else $error("temperature nonzero on fault or stuck");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.status == ST_VALID || result_out.status == ST_FAULT ||
                          result_out.status == ST_STUCK))
    else $error("bad status code");

endmodule

[test/rtdal_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtdal_checker
// Watches the reading and result channels of rtd_average_and_linearize,
// predicts each result from its own copy of the registers and sample ring,
// and compares every result beat field by field in arrival order.
// ---------------------------------------------------------------------------
module rtdal_checker
  import rtdal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  rtdal_in_if                   sample_in,
  rtdal_out_if                  result_out,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [1:0]         status;
    logic [14:0]        code;
    logic signed [18:0] temp;
  } reading_t;

  reading_t          expected_q[$];
  logic [4:0]        avg_count;
  logic [23:0]       ref_ohms;
  logic [23:0]       nom_ohms;
  logic [30:0]       coef_a;
  logic [40:0]       coef_b;
  logic [14:0]       ring[AVG_DEPTH];
  int unsigned       ring_pos;

  assign pending = expected_q.size();

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] rem, res, bitv;
    rem = v;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [18:0] linearize(logic [14:0] code);
    logic [63:0] r0, bmag, a, x, t, d, s, mag, q;
    logic        neg;
    r0 = (nom_ohms == 0) ? 64'd1 : 64'(nom_ohms);
    bmag = coef_b[40] ? (64'd1 << 41) - 64'(coef_b) : 64'd1;
    a = 64'(coef_a);
    x = (64'(code) * 64'(ref_ohms) * 64'd32) / r0;
    if (x > (64'd1 << 24)) x = 64'd1 << 24;
    if (x <= (64'd1 << 20)) begin
      t = (bmag * ((64'd1 << 20) - x)) >> 2;
      d = a * a + t;
    end else begin
      t = (bmag * (x - (64'd1 << 20))) >> 2;
      // negative discriminant saturates high
      if (t > a * a) return T_MAX;
      d = a * a - t;
    end
    s = root_floor(d);
    neg = s > a;
    mag = neg ? s - a : a - s;
    q = ((mag << 23) + bmag / 2) / bmag;
    if (neg) begin
      if (q > 64'd65536) q = 64'd65536;
      return 19'((64'd1 << 19) - q);
    end
    if (q > 64'd262143) q = 64'd262143;
    return 19'(q);
  endfunction

  always @(posedge clk) begin
    reading_t    r, got;
    logic [14:0] code;
    int unsigned cnt;
    logic [31:0] sum;
    if (rst) begin
      avg_count <= 5'd1;
      ref_ohms <= 24'd110080;
      nom_ohms <= 24'd25600;
      coef_a <= 31'd16786021;
      coef_b <= 41'((64'd1 << 41) - 64'd162551799);
      for (int i = 0; i < AVG_DEPTH; i++) ring[i] = '0;
      ring_pos = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_AVG_COUNT: avg_count <= wr_data[4:0];
          REG_REF_OHMS:  ref_ohms <= wr_data[23:0];
          REG_NOM_OHMS:  nom_ohms <= wr_data[23:0];
          REG_COEF_A:    coef_a <= wr_data[30:0];
          REG_COEF_B:    coef_b <= wr_data[40:0];
          default: ;
        endcase
      end
      if (result_out.valid && result_out.ready) begin
        got.status = result_out.status;
        got.code = result_out.code_out;
        got.temp = result_out.temperature_q8;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          r = expected_q.pop_front();
          if (got.status !== r.status)
            $error("status expected %0d actual %0d", r.status, got.status);
          if (got.code !== r.code)
            $error("code_out expected %0d actual %0d", r.code, got.code);
          if (got.temp !== r.temp)
            $error("temperature_q8 expected %0d actual %0d", r.temp, got.temp);
          if (got !== r) fail_count <= fail_count + 1;
        end
      end
      if (sample_in.valid && sample_in.ready) begin
        code = 15'({sample_in.code_high_byte, 7'd0} + (sample_in.code_low_byte >> 1));
        if (sample_in.code_low_byte[0]) begin
          r = '{ST_FAULT, code, 19'sd0};
        end else if (code == 0) begin
          r = '{ST_STUCK, 15'd0, 19'sd0};
        end else begin
          cnt = (avg_count == 0) ? 1 : (avg_count > AVG_DEPTH ? AVG_DEPTH : avg_count);
          if (cnt > 1) begin
            if (ring_pos >= cnt) ring_pos = 0;
            ring[ring_pos] = code;
            ring_pos++;
            sum = 0;
            for (int i = 0; i < cnt; i++) sum += ring[i];
            code = 15'(sum / cnt);
          end
          r = '{ST_VALID, code, linearize(code)};
        end
        expected_q.push_back(r);
      end
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives raw readings through rtd_average_and_linearize under several
// register settings with random gaps and stalls; a checker predicts results.
// ---------------------------------------------------------------------------
module testbench;
  import rtdal_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_READINGS = 1450;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  wr_en = 0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  int                    fail_count;
  int                    pending;
  int                    cycles = 0;
  int                    stall_left = 0;

  rtdal_in_if  sample_in();
  rtdal_out_if result_out();

  rtd_average_and_linearize dut (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .sample_in(sample_in.sink), .result_out(result_out.source)
  );

  rtdal_checker checker_i (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .sample_in(sample_in), .result_out(result_out),
    .fail_count, .pending
  );

  always #6 clk = ~clk;

  initial begin
    sample_in.valid = 0;
    sample_in.code_high_byte = 0;
    sample_in.code_low_byte = 0;
    result_out.ready = 0;
  end

  // receiver stalls, drawn per beat
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else if (result_out.valid && result_out.ready) begin
      stall_left = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) stall_left = 0;
      result_out.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      result_out.ready <= (stall_left == 0);
    end else begin
      result_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rtd_average_and_linearize verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // valid stays high into the next beat when there is no gap
  task automatic send_reading(logic [7:0] hi, logic [7:0] lo, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      sample_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_in.valid <= 1'b1;
    sample_in.code_high_byte <= hi;
    sample_in.code_low_byte <= lo;
    do @(posedge clk); while (!sample_in.ready);
  endtask

  task automatic pause_sender();
    sample_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic drain();
    pause_sender();
    repeat (400) @(posedge clk);
  endtask

  // mostly plausible pt100/pt1000 codes, some full-range noise and faults
  task automatic random_reading(bit burst);
    logic [7:0] hi, lo;
    hi = $urandom_range(0, 255);
    lo = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: lo[0] = 1'b1;
      1: begin hi = 0; lo = $urandom_range(0, 1); end
      2, 3: ;
      default: begin hi = $urandom_range(40, 140); lo[0] = 1'b0; end
    endcase
    send_reading(hi, lo, burst);
  endtask

  task automatic random_phase(int n);
    bit burst;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) burst = ($urandom_range(0, 2) == 0);
      random_reading(burst);
      if (i == n / 2) pause_sender();
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, fault, stuck, defaults without averaging
    send_reading(8'hFF, 8'hFE, 0);
    send_reading(8'hFF, 8'hFF, 0);
    send_reading(8'h00, 8'h00, 0);
    send_reading(8'h00, 8'h01, 0);
    send_reading(8'h00, 8'h02, 0);
    send_reading(8'h00, 8'h80, 0);
    send_reading(8'h55, 8'hAA, 1);
    send_reading(8'hAA, 8'h54, 1);
    send_reading(8'h64, 8'h00, 0);
    send_reading(8'h01, 8'h00, 0);
    drain();
    // averaging over four, entries never written count as zero
    write_reg(REG_AVG_COUNT, 41'd4);
    for (int i = 0; i < 6; i++) send_reading(8'(60 + 10 * i), 8'(i * 40), 0);
    drain();
    // count zero acts as one; count above depth acts as depth; B not negative
    write_reg(REG_AVG_COUNT, 41'd0);
    write_reg(REG_NOM_OHMS, 41'd0);
    write_reg(REG_COEF_B, 41'd5);
    send_reading(8'h10, 8'h20, 0);
    send_reading(8'h80, 8'h00, 0);
    drain();
    write_reg(REG_AVG_COUNT, 41'd31);
    write_reg(REG_NOM_OHMS, 41'd25600);
    write_reg(REG_COEF_B, {1'b1, 40'd0});
    write_reg(REG_COEF_A, 41'h7FFFFFFF);
    write_reg(REG_REF_OHMS, 41'hFFFFFF);
    send_reading(8'hFF, 8'hFE, 0);
    send_reading(8'h01, 8'h02, 0);
    drain();

    // random phases under several settings
    write_reg(REG_AVG_COUNT, 41'd1);
    write_reg(REG_REF_OHMS, 41'd110080);
    write_reg(REG_COEF_A, 41'd16786021);
    write_reg(REG_COEF_B, 41'((64'd1 << 41) - 64'd162551799));
    random_phase(RANDOM_READINGS / 5);
    write_reg(REG_AVG_COUNT, 41'd8);
    random_phase(RANDOM_READINGS / 5);
    write_reg(REG_AVG_COUNT, 41'd16);
    write_reg(REG_REF_OHMS, 41'd1);
    write_reg(REG_NOM_OHMS, 41'hFFFFFF);
    random_phase(RANDOM_READINGS / 5);
    write_reg(REG_AVG_COUNT, 41'd3);
    write_reg(REG_REF_OHMS, 41'd1100800);
    write_reg(REG_NOM_OHMS, 41'd256000);
    write_reg(REG_COEF_B, 41'h1FFFFFFFFFF);
    write_reg(REG_COEF_A, 41'd0);
    random_phase(RANDOM_READINGS / 5);
    write_reg(REG_AVG_COUNT, 41'd2);
    write_reg(REG_NOM_OHMS, 41'd1);
    write_reg(REG_COEF_A, 41'd16786021);
    write_reg(REG_COEF_B, 41'((64'd1 << 41) - 64'd162551799));
    random_phase(RANDOM_READINGS / 5);

    if (fail_count == 0)
      $display("rtd_average_and_linearize verification clean");
    else
      $display("rtd_average_and_linearize verification failed");
    $finish;
  end

endmodule
